// File: rtl/rtt_estimator_top_macros.svh
// Assertion macros for the RTT estimator.
// Both expect clk_i in the scope of the use; RTT_ASSERT also expects rst_ni.
`ifndef RTT_ESTIMATOR_TOP_MACROS_SVH
`define RTT_ESTIMATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define RTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define RTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RTT_ASSERT(lbl, prop, msg)
`define RTT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/rtt_est_pkg.sv
package rtt_est_pkg;

  // Field widths
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned SAMPLE_W = 61;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned ADDR_W   = 4;

  // Filter shifts: srtt kept scaled by 8, variance gain 1/4, first variance s/2
  localparam int unsigned SRTT_SHIFT = 3;
  localparam int unsigned VAR_SHIFT  = 2;
  localparam int unsigned INIT_SHIFT = 1;

  // Register index (byte address bit 3 selects the 64-bit register)
  localparam logic REG_MAX_ACK_DELAY = 1'b0;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] send_time;
    logic [TIME_W-1:0] reported_delay;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic [SAMPLE_W-1:0] sample_rtt;
    logic [SAMPLE_W-1:0] smoothed_rtt;
    logic [SAMPLE_W-1:0] rtt_variance;
    logic [SAMPLE_W-1:0] min_rtt;
  } out_item_t;

  // Adjusted sample handed from the sample stage to the update stage
  typedef struct packed {
    logic                ok;
    logic [SAMPLE_W-1:0] sample;
  } sample_t;

endpackage

// File: rtl/rtt_est_sample.sv
module rtt_est_sample (
  input  rtt_est_pkg::in_item_t        item_i,
  input  logic [rtt_est_pkg::TIME_W-1:0] max_ack_delay_i,
  output rtt_est_pkg::sample_t         sample_o
);

  logic [rtt_est_pkg::TIME_W-1:0] raw;
  logic [rtt_est_pkg::TIME_W-1:0] dly;
  logic [rtt_est_pkg::TIME_W-1:0] adj;
  logic                           time_ok;
  logic                           ok;

  // Raw sample and clamped peer delay
  assign time_ok = item_i.now_time > item_i.send_time;
  assign raw     = item_i.now_time - item_i.send_time;
  assign dly     = (item_i.reported_delay < max_ack_delay_i) ? item_i.reported_delay
                                                            : max_ack_delay_i;

  // Take the delay off only when nonzero and below the sample
  assign adj = ((dly != '0) && (raw > dly)) ? (raw - dly) : raw;

  // Reject time not advancing and samples that do not fit the field
  assign ok = time_ok && (adj[rtt_est_pkg::TIME_W-1:rtt_est_pkg::SAMPLE_W] == '0);

  assign sample_o.ok     = ok;
  assign sample_o.sample = ok ? adj[rtt_est_pkg::SAMPLE_W-1:0] : '0;

endmodule

// File: rtl/rtt_est_update.sv
`include "rtt_estimator_top_macros.svh"

module rtt_est_update (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   commit_i,
  input  rtt_est_pkg::sample_t   sample_i,
  output rtt_est_pkg::out_item_t result_o
);

  localparam int unsigned SW = rtt_est_pkg::SAMPLE_W;
  localparam int unsigned TW = rtt_est_pkg::TIME_W;
  localparam int unsigned PW = TW - SW;

  logic [TW-1:0] srtt8_q, srtt8_d, srtt8_upd;
  logic [SW-1:0] var_q, var_d, var_upd;
  logic [SW-1:0] min_q, min_d, min_upd;
  logic [SW-1:0] s;
  logic [SW-1:0] avg;
  logic [SW-1:0] dev;
  logic          first;

  assign s     = sample_i.sample;
  assign first = (srtt8_q == '0);
  assign avg   = srtt8_q[TW-1:rtt_est_pkg::SRTT_SHIFT];

  // Filter terms for a later sample
  assign dev       = (avg > s) ? (avg - s) : (s - avg);
  assign srtt8_upd = srtt8_q - {{PW{1'b0}}, avg} + {{PW{1'b0}}, s};
  assign var_upd   = var_q - (var_q >> rtt_est_pkg::VAR_SHIFT)
                     + (dev >> rtt_est_pkg::VAR_SHIFT);
  assign min_upd   = (s < min_q) ? s : min_q;

  // Next state: first sample seeds, later ones filter, invalid ones hold
  always_comb begin
    srtt8_d = srtt8_q;
    var_d   = var_q;
    min_d   = min_q;
    if (sample_i.ok) begin
      if (first) begin
        srtt8_d = {s, {rtt_est_pkg::SRTT_SHIFT{1'b0}}};
        var_d   = s >> rtt_est_pkg::INIT_SHIFT;
        min_d   = s;
      end else begin
        srtt8_d = srtt8_upd;
        var_d   = var_upd;
        min_d   = min_upd;
      end
    end
  end

  // Estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srtt8_q <= '0;
      var_q   <= '0;
      min_q   <= '0;
    end else if (commit_i) begin
      srtt8_q <= srtt8_d;
      var_q   <= var_d;
      min_q   <= min_d;
    end
  end

  // Result reflects the state after this sample
  assign result_o.status       = sample_i.ok ? rtt_est_pkg::STATUS_OK
                                             : rtt_est_pkg::STATUS_INVALID;
  assign result_o.sample_rtt   = s;
  assign result_o.smoothed_rtt = srtt8_d[TW-1:rtt_est_pkg::SRTT_SHIFT];
  assign result_o.rtt_variance = var_d;
  assign result_o.min_rtt      = min_d;

  `RTT_ASSERT(a_seeded, commit_i && sample_i.ok |=> srtt8_q != '0, "srtt not seeded")
  `RTT_ASSERT(a_min_falls,
    commit_i && sample_i.ok && !first |=> min_q <= $past(min_q), "min rose")
  `RTT_ASSERT(a_hold,
    commit_i && !sample_i.ok |=> $stable(srtt8_q) && $stable(var_q) && $stable(min_q),
    "state moved")

endmodule

// File: rtl/rtt_estimator_top.sv
// RTT estimator: takes one acknowledgement transfer per clock while the input is not
// stalled and returns one result per transfer, in order. The path is three registers
// deep: an input register, a sample register holding the delay-adjusted sample, and a
// result register. The smoothed RTT, variance and minimum are updated in the single
// cycle in which a sample moves into the result register, so back-to-back acks see
// each other's updates. max_ack_delay is a 64-bit register at byte address 0 of the APB
// port and may be written only while no transfer is in flight.
`include "rtt_estimator_top_macros.svh"

module rtt_estimator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  rtt_est_pkg::in_item_t              in_item_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output rtt_est_pkg::out_item_t             out_item_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rtt_est_pkg::ADDR_W-1:0]     paddr,
  input  logic [rtt_est_pkg::DATA_W-1:0]     pwdata,
  output logic [rtt_est_pkg::DATA_W-1:0]     prdata,
  output logic                               pready
);

  logic [rtt_est_pkg::TIME_W-1:0] max_ack_delay_q;
  logic                           reg_sel;
  logic                           cfg_wr;

  logic                   in_v_q, smp_v_q, out_v_q;
  logic                   rdy0, rdy1, rdy2;
  rtt_est_pkg::in_item_t  in_q;
  rtt_est_pkg::sample_t   smp_d, smp_q;
  rtt_est_pkg::out_item_t res_d, res_q;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[rtt_est_pkg::ADDR_W-1] == rtt_est_pkg::REG_MAX_ACK_DELAY);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? max_ack_delay_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ack_delay_q <= '0;
    end else if (cfg_wr) begin
      max_ack_delay_q <= pwdata;
    end
  end

  // Stage advance: a stage loads when it is empty or its content moves on
  assign rdy2       = !out_v_q || !out_stall_i;
  assign rdy1       = !smp_v_q || rdy2;
  assign rdy0       = !in_v_q || rdy1;
  assign in_stall_o = !rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      smp_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy0) in_v_q  <= in_valid_i;
      if (rdy1) smp_v_q <= in_v_q;
      if (rdy2) out_v_q <= smp_v_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) in_q  <= in_item_i;
    if (rdy1 && in_v_q)     smp_q <= smp_d;
    if (rdy2 && smp_v_q)    res_q <= res_d;
  end

  rtt_est_sample u_sample (
    .item_i          (in_q),
    .max_ack_delay_i (max_ack_delay_q),
    .sample_o        (smp_d)
  );

  rtt_est_update u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (rdy2 && smp_v_q),
    .sample_i (smp_q),
    .result_o (res_d)
  );

  assign out_valid_o = out_v_q;
  assign out_item_o  = res_q;

  `RTT_ASSERT(a_stall_full, in_stall_o |-> in_v_q && smp_v_q && out_v_q, "stall with room")
  `RTT_ASSERT(a_ok_nonzero,
    out_valid_o && (out_item_o.status == rtt_est_pkg::STATUS_OK) |->
      out_item_o.sample_rtt != '0,
    "zero sample ok")
  // Registers are cleared asynchronously by reset, so the design is empty while in reset
  `RTT_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o && !in_stall_o, "busy in reset")

endmodule

// File: tb/sv/tb_rtt_estimator_top.sv
module tb_rtt_estimator_top;

  localparam int unsigned RUN_LIMIT      = 800_000;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned RAND_PHASES    = 5;
  localparam int unsigned ACKS_PER_PHASE = 160;
  localparam int unsigned TW             = rtt_est_pkg::TIME_W;
  localparam int unsigned SW             = rtt_est_pkg::SAMPLE_W;
  localparam logic [TW-1:0] SAMPLE_CEIL  = 64'd1 << rtt_est_pkg::SAMPLE_W;
  localparam logic [TW-1:0] ALL_ONES     = '1;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_EVERY3, RX_CHOKE} rx_mode_e;

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_stall_o;
  rtt_est_pkg::in_item_t             in_item_i   = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  rtt_est_pkg::out_item_t            out_item_o;
  logic                              psel        = 1'b0;
  logic                              penable     = 1'b0;
  logic                              pwrite      = 1'b0;
  logic [rtt_est_pkg::ADDR_W-1:0]    paddr       = '0;
  logic [rtt_est_pkg::DATA_W-1:0]    pwdata      = '0;
  logic [rtt_est_pkg::DATA_W-1:0]    prdata;
  logic                              pready;

  rtt_estimator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // acks waiting to be driven, and results predicted for accepted acks
  rtt_est_pkg::in_item_t  ack_q[$];
  rtt_est_pkg::out_item_t rtt_expect_q[$];

  // estimator state mirrored by the predictor
  logic [TW-1:0] srtt_x8       = '0;
  logic [TW-1:0] rttvar        = '0;
  logic [TW-1:0] rtt_floor     = '0;
  logic [TW-1:0] ack_delay_cap = '0;

  int unsigned err_cnt      = 0;
  int unsigned acks_total   = 0;
  int unsigned acks_invalid = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes   = 0;
  int unsigned in_stalls    = 0;
  int unsigned long_holds   = 0;

  logic        ack_taken  = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  logic        hold_req   = 1'b0;
  int unsigned hold_cnt   = 0;
  int unsigned mode_left  = 0;
  int unsigned rx_tick    = 0;
  rx_mode_e    rx_mode    = RX_FLOW;

  task automatic flag_error(input string msg);
    err_cnt++;
    $display("ERROR t=%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [SW-1:0] got,
                             input logic [SW-1:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                           results_seen, name, got, want));
  endtask

  function automatic logic [TW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Jacobson/Karels update for one ack; advances the mirrored state
  function automatic rtt_est_pkg::out_item_t estimate_rtt(rtt_est_pkg::in_item_t ack);
    rtt_est_pkg::out_item_t res;
    logic [TW-1:0]          s;
    logic [TW-1:0]          dly;
    logic [TW-1:0]          avg;
    logic [TW-1:0]          dev;
    logic                   ok;
    s  = '0;
    ok = 1'b0;
    if (ack.now_time > ack.send_time) begin
      s   = ack.now_time - ack.send_time;
      dly = (ack.reported_delay < ack_delay_cap) ? ack.reported_delay : ack_delay_cap;
      // delay only comes off when it is nonzero and below the raw sample
      if (dly != '0 && s > dly)
        s = s - dly;
      if (s < SAMPLE_CEIL) begin
        ok = 1'b1;
        if (srtt_x8 == '0) begin
          // first valid sample seeds everything
          srtt_x8   = s << rtt_est_pkg::SRTT_SHIFT;
          rttvar    = s >> rtt_est_pkg::INIT_SHIFT;
          rtt_floor = s;
        end else begin
          avg     = srtt_x8 >> rtt_est_pkg::SRTT_SHIFT;
          dev     = (avg > s) ? avg - s : s - avg;
          srtt_x8 = (srtt_x8 - avg) + s;
          rttvar  = rttvar - (rttvar >> rtt_est_pkg::VAR_SHIFT)
                    + (dev >> rtt_est_pkg::VAR_SHIFT);
          if (s < rtt_floor)
            rtt_floor = s;
        end
      end
    end
    if (!ok)
      s = '0;
    res.status       = ok ? rtt_est_pkg::STATUS_OK : rtt_est_pkg::STATUS_INVALID;
    res.sample_rtt   = s[SW-1:0];
    res.smoothed_rtt = SW'(srtt_x8 >> rtt_est_pkg::SRTT_SHIFT);
    res.rtt_variance = rttvar[SW-1:0];
    res.min_rtt      = rtt_floor[SW-1:0];
    return res;
  endfunction

  // Monitor: check results first, then record accepted acks
  always @(posedge clk_i) begin : monitor
    rtt_est_pkg::out_item_t want;
    rtt_est_pkg::in_item_t  ack;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (rtt_expect_q.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = rtt_expect_q.pop_front();
          check_field("status", SW'(out_item_o.status), SW'(want.status));
          check_field("sample_rtt", out_item_o.sample_rtt, want.sample_rtt);
          check_field("smoothed_rtt", out_item_o.smoothed_rtt, want.smoothed_rtt);
          check_field("rtt_variance", out_item_o.rtt_variance, want.rtt_variance);
          check_field("min_rtt", out_item_o.min_rtt, want.min_rtt);
        end
      end
      if (in_valid_i && in_stall_o)
        in_stalls++;
      if (in_valid_i && !in_stall_o) begin
        ack  = ack_q.pop_front();
        want = estimate_rtt(ack);
        rtt_expect_q.push_back(want);
        acks_total++;
        if (want.status == rtt_est_pkg::STATUS_INVALID)
          acks_invalid++;
        ack_taken = 1'b1;
      end
    end
  end

  // Driver: bursts of back-to-back acks separated by random gaps
  always @(negedge clk_i) begin : driver
    if (!in_valid_i || ack_taken) begin
      ack_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (ack_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_item_i  <= ack_q[0];
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: changing stall patterns, plus long hold-offs on request
  always @(negedge clk_i) begin : receiver
    rx_tick++;
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = LONG_HOLD - 1;
      long_holds++;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (rx_mode)
        RX_FLOW:   out_stall_i <= 1'b0;
        RX_COIN:   out_stall_i <= 1'($urandom_range(0, 1));
        RX_EVERY3: out_stall_i <= (rx_tick % 3 == 0);
        default:   out_stall_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic queue_ack(input logic [TW-1:0] now_t, input logic [TW-1:0] sent_t,
                           input logic [TW-1:0] dly);
    rtt_est_pkg::in_item_t it;
    it.now_time       = now_t;
    it.send_time      = sent_t;
    it.reported_delay = dly;
    ack_q.push_back(it);
  endtask

  // APB write of max_ack_delay, then read it back
  task automatic write_ack_delay_cap(input logic [rtt_est_pkg::DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {rtt_est_pkg::REG_MAX_ACK_DELAY, 3'b000};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ack_delay_cap = val;
    cfg_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val)
      flag_error($sformatf("max_ack_delay read 0x%0h, wrote 0x%0h", prdata, val));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // sender pause: everything accepted and every result back
  task automatic wait_drained();
    while (ack_q.size() != 0 || rtt_expect_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // one random ack: mostly plausible acks, some noise and broken ones
  task automatic queue_random_ack();
    logic [TW-1:0] now_t;
    logic [TW-1:0] rtt;
    logic [TW-1:0] dly;
    int unsigned   pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      case ($urandom_range(0, 9)) inside
        [0:5]:   rtt = 64'($urandom_range(1, 500_000));
        [6:7]:   rtt = (rand64() >> $urandom_range(3, 63)) + 64'd1;
        8:       rtt = (rand64() >> 3) + 64'd1;
        default: rtt = 64'($urandom_range(1, 10));
      endcase
      now_t = rand64();
      if (now_t < rtt)
        now_t = now_t + rtt;
      case ($urandom_range(0, 9)) inside
        0:       dly = '0;
        [1:4]:   dly = rand64() % (rtt + 64'd1);
        5:       dly = rtt;
        6:       dly = rand64();
        7:       dly = rtt - 64'd1;
        default: dly = 64'($urandom_range(0, 30_000));
      endcase
      queue_ack(now_t, now_t - rtt, dly);
    end else if (pick < 85) begin
      queue_ack(rand64(), rand64(), rand64());
    end else begin
      now_t = rand64();
      case ($urandom_range(0, 2))
        0:       queue_ack(now_t, now_t, rand64());
        1:       queue_ack(now_t & {2'b00, ALL_ONES[61:0]}, now_t | {2'b11, 62'd0},
                           rand64());
        default: queue_ack(SAMPLE_CEIL + (rand64() >> 3), 64'd0, 64'd0);
      endcase
    end
  endtask

  initial begin : stimulus
    logic [rtt_est_pkg::DATA_W-1:0] cap;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // cap still at its reset value of zero
    queue_ack(64'd100, 64'd100, 64'd0);       // time standing still, before any sample
    queue_ack(64'd5, 64'd900, 64'd0);         // time going backwards
    queue_ack(ALL_ONES, 64'd0, 64'd0);        // oversized sample
    queue_ack(64'd1000, 64'd0, 64'd0);        // direct first sample
    queue_ack(64'd5000, 64'd1000, 64'd300);   // zero cap: nothing subtracted
    queue_ack(ALL_ONES, ALL_ONES - 64'd1, ALL_ONES);  // one-microsecond sample
    queue_ack(SAMPLE_CEIL - 64'd1, 64'd0, 64'd0);     // largest valid sample
    queue_ack(SAMPLE_CEIL, 64'd0, 64'd0);             // just over the limit
    wait_drained();

    write_ack_delay_cap(64'd25_000);
    queue_ack(64'd20_000, 64'd10_000, 64'd2_500);   // delay subtracted
    queue_ack(64'd30_000, 64'd10_000, 64'd20_000);  // delay equals sample
    queue_ack(64'd30_000, 64'd25_000, 64'd9_000);   // delay above sample
    queue_ack(64'd200_000, 64'd100_000, 64'd60_000);  // clamped delay
    queue_ack(64'd200_000, 64'd100_000, ALL_ONES);    // clamped from all ones
    queue_ack(SAMPLE_CEIL + 64'd10_000, 64'd0, 64'd20_000);  // back under the limit
    queue_ack(SAMPLE_CEIL + 64'd30_000, 64'd0, 64'd40_000);  // clamp keeps it over
    queue_ack(64'd7_000, 64'd0, 64'd0);              // zero reported delay
    wait_drained();

    write_ack_delay_cap(ALL_ONES);
    queue_ack(ALL_ONES, 64'd0, ALL_ONES - 64'd1);
    queue_ack(ALL_ONES, 64'd0, ALL_ONES);
    queue_ack(ALL_ONES, 64'd1, 64'd0);
    queue_ack(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFF0, 64'd3);
    wait_drained();

    // random phases, one cap setting each
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       cap = ALL_ONES;
        1:       cap = '0;
        2:       cap = 64'($urandom_range(0, 50_000));
        3:       cap = rand64();
        default: cap = 64'h8000_0000_0000_0000;
      endcase
      write_ack_delay_cap(cap);
      if (p == 1 || p == 3) begin
        @(posedge clk_i);
        hold_req = 1'b1;
      end
      for (int i = 0; i < ACKS_PER_PHASE; i++)
        queue_random_ack();
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("Covered %0d acks (%0d rejected), %0d results checked, %0d cap writes.",
             acks_total, acks_invalid, results_seen, cfg_writes);
    $display("Input held off on %0d cycles; %0d long output hold-offs.",
             in_stalls, long_holds);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("Timeout: %0d results still expected", rtt_expect_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
